// ===== rtl/core/ppba_pkg.sv =====
// Package: constants and types shared by the per-process burst alert table.
package ppba_pkg;
    localparam int unsigned MAX_WINDOWS_DEF = 32;
    localparam logic [63:0] IDLE_MS = 64'd60000;
    localparam logic [31:0] DEF_WINDOW_MS = 32'd1000;
    localparam logic [31:0] DEF_COOLDOWN_MS = 32'd5000;
    localparam logic [31:0] MUTATING_BITS = 32'h0000_07CE;
    localparam logic [31:0] WATCHED_BITS = 32'h1005_0EEA;
    localparam logic [31:0] PERM_BITS = 32'h0007_0000;
    localparam logic [31:0] DELETE_BITS = 32'h0000_0600;
    localparam logic [31:0] RENAME_BITS = 32'h1000_08C0;
    localparam logic [31:0] MODIFY_BITS = 32'h0000_000A;
    localparam logic [31:0] OPEN_BITS = 32'h0005_0020;

    localparam logic [2:0] RSN_NONE = 3'd0;
    localparam logic [2:0] RSN_DELETED = 3'd1;
    localparam logic [2:0] RSN_RENAMED = 3'd2;
    localparam logic [2:0] RSN_MODIFIED = 3'd3;
    localparam logic [2:0] RSN_OPENED = 3'd4;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN = 2'd2;
    localparam logic [1:0] CFG_DENY = 2'd3;
    localparam int unsigned CFG_IDX_W = 2;

    // one table entry as held in the state memory
    typedef struct packed {
        logic [21:0] proc_id;
        logic [63:0] window_start;
        logic [63:0] last_activity;
        logic [63:0] last_alert;
        logic [31:0] event_count;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    function automatic logic [2:0] reason_of(input logic [31:0] m);
        logic [2:0] r;
        r = RSN_NONE;
        if ((m & DELETE_BITS) != '0) r = RSN_DELETED;
        else if ((m & RENAME_BITS) != '0) r = RSN_RENAMED;
        else if ((m & MODIFY_BITS) != '0) r = RSN_MODIFIED;
        else if ((m & OPEN_BITS) != '0) r = RSN_OPENED;
        return r;
    endfunction
endpackage

// ===== rtl/core/per_process_burst_alert_table.sv =====
// Top level: per-process burst alert table with memory-held entries.
// Usage:
//   Slave channel s_axis_* carries one request per file event or idle tick.
//   tdata = {canary_path_match, event_mask, timestamp_ms, proc_id} from bit 0,
//   tuser = req_type (0 event, 1 sweep tick).
//   Master channel m_axis_* returns one result per request (verdict and
//   alert fields in tdata, table_full in tuser-free tdata, see port notes).
//   Config is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
//   must write it only while the block is idle; the block itself does not enforce it.
// Sequence:
//   The entry memory has one port and a registered read. A request scans
//   all MAX_WINDOWS entries in ST_SCAN (one read a cycle, pipelined),
//   re-reads the chosen entry through ST_RD and ST_OUT and writes it back
//   in ST_MOD. The next request is taken only after the return to ST_IDLE,
//   so a new request is not accepted before the last one is finished.
//   A tick takes the same path.
//   The write-back and the result register load happen together.
// Reset: all valid bits clear (flip-flops), config and state registers take defaults; the
//   memory itself is not cleared. A stalled master side holds the result and
//   keeps s_axis_tready low once the next request has finished too.
module per_process_burst_alert_table #(
    parameter int unsigned MAX_WINDOWS = ppba_pkg::MAX_WINDOWS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // proc_id[21:0], timestamp_ms[85:22], event_mask[117:86],
    // canary_path_match[118], zero fill to 120
    input  logic [119:0] s_axis_tdata,
    // req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // verdict[0], canary_alert[1], canary_reason_code[4:2], burst_alert[5],
    // burst_count[37:6], table_full[38], entries_in_use[44:39], zero fill to 48
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [ppba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import ppba_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WINDOWS);
    localparam int unsigned CW = $clog2(MAX_WINDOWS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WINDOWS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RD = 3'd2;
    localparam logic [2:0] ST_MOD = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    // config
    logic [15:0] r_thr;
    logic [31:0] r_win, r_cool;
    logic        r_deny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_win <= DEF_WINDOW_MS;
            r_cool <= DEF_COOLDOWN_MS;
            r_deny <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_thr <= i_cfg_data[15:0];
                CFG_WINDOW: r_win <= (i_cfg_data != '0) ? i_cfg_data : DEF_WINDOW_MS;
                CFG_COOLDOWN: r_cool <= (i_cfg_data != '0) ? i_cfg_data : DEF_COOLDOWN_MS;
                CFG_DENY: r_deny <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // request registers
    logic        r_tick, r_canary;
    logic [21:0] r_pid;
    logic [63:0] r_now;
    logic [31:0] r_mask;

    logic [2:0]    r_state;
    logic [AW-1:0] r_addr;      // address presented this cycle
    logic          r_chk;       // rdata valid for r_chk_idx
    logic [AW-1:0] r_chk_idx;
    logic          r_last;      // current check is the final one
    logic          r_hit, r_free_ok;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    logic [MAX_WINDOWS-1:0] r_valid;
    logic [CW-1:0] r_used;

    logic          r_out_v;
    logic [47:0]   r_out;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_entry        mem_wdata, mem_rdata, e;

    ppba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WINDOWS)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = r_out;

    // result register free to take the finished request
    logic out_go;
    assign out_go = (r_state == ST_MOD) && (!r_out_v || m_axis_tready);

    // event decode
    logic [2:0] rsn;
    logic need_can, need_bur, need_any;
    assign rsn = reason_of(r_mask);
    assign need_can = ((r_mask & WATCHED_BITS) != '0) && r_canary && (rsn != RSN_NONE);
    assign need_bur = (r_thr != '0) && ((r_mask & MUTATING_BITS) != '0);
    assign need_any = need_can || need_bur;

    // modify datapath for the chosen entry (fresh entry when allocating)
    logic [AW-1:0] tgt;
    logic          cooled0, cooled1, can_hit, bur_hit, new_win;
    logic [31:0]   cnt1;
    logic [63:0]   la1;
    t_entry        upd;
    logic          full;

    assign full = !r_hit && !r_free_ok;
    assign tgt = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        if (r_hit) begin
            e = mem_rdata;
        end else begin
            e.proc_id = r_pid;
            e.window_start = '0;
            e.last_activity = r_now;
            e.last_alert = '0;
            e.event_count = '0;
        end
        cooled0 = (e.last_alert == '0) || ((r_now - e.last_alert) >= {32'd0, r_cool});
        can_hit = need_can && cooled0;
        la1 = can_hit ? r_now : e.last_alert;
        // a canary alert just stamped now blocks the burst unless now is zero
        cooled1 = can_hit ? (r_now == '0) : cooled0;
        upd = e;
        upd.last_alert = la1;
        upd.last_activity = r_now;
        new_win = (e.event_count == '0) || ((r_now - e.window_start) > {32'd0, r_win});
        cnt1 = e.event_count;
        bur_hit = 1'b0;
        if (need_bur) begin
            if (new_win) begin
                upd.window_start = r_now;
                cnt1 = 32'd1;
            end else if (e.event_count != 32'hFFFF_FFFF) begin
                cnt1 = e.event_count + 32'd1;
            end
            upd.event_count = cnt1;
            bur_hit = (cnt1 >= {16'd0, r_thr}) && cooled1;
            if (bur_hit) begin
                upd.last_alert = r_now;
                upd.event_count = '0;
                upd.window_start = r_now;
            end
        end
    end

    logic idle_old;
    assign idle_old = (r_now - mem_rdata.last_activity) > IDLE_MS;

    always_comb begin
        mem_we = 1'b0;
        mem_wdata = upd;
        mem_addr = r_addr;
        if (out_go && !r_tick && need_any && !full) begin
            mem_we = 1'b1;
            mem_addr = tgt;
        end
    end

    logic [CW-1:0] used_n;
    always_comb begin
        used_n = r_used;
        if (r_state == ST_MOD && !r_tick && need_any && !r_hit && r_free_ok) begin
            used_n = r_used + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_tick <= s_axis_tuser;
            r_pid <= s_axis_tdata[21:0];
            r_now <= s_axis_tdata[85:22];
            r_mask <= s_axis_tdata[117:86];
            r_canary <= s_axis_tdata[118];
        end
        if (out_go) begin
            r_out <= {3'd0, 6'(used_n), !r_tick && need_any && full,
                      bur_hit && !r_tick && !full ? cnt1 : 32'd0,
                      bur_hit && !r_tick && !full,
                      can_hit && !r_tick && !full ? rsn : RSN_NONE,
                      can_hit && !r_tick && !full,
                      (can_hit || bur_hit) && !r_tick && !full &&
                          ((r_mask & PERM_BITS) != '0) && r_deny};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_used <= '0;
            r_out_v <= 1'b0;
            r_chk <= 1'b0;
            r_addr <= '0;
        end else begin
            if (out_go) r_out_v <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_SCAN;
                        r_addr <= '0;
                        r_chk <= 1'b0;
                        r_hit <= 1'b0;
                        r_free_ok <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // address r_addr issued; check the entry read last cycle
                    r_chk <= !(r_chk && r_last);
                    r_chk_idx <= r_addr;
                    r_last <= (r_addr == LAST_IDX);
                    if (r_addr != LAST_IDX) r_addr <= r_addr + AW'(1);
                    if (r_chk && r_valid[r_chk_idx]) begin
                        if (r_tick) begin
                            if (idle_old) begin
                                r_valid[r_chk_idx] <= 1'b0;
                                r_used <= r_used - CW'(1);
                            end
                        end else if (!r_hit && mem_rdata.proc_id == r_pid) begin
                            r_hit <= 1'b1;
                            r_hit_idx <= r_chk_idx;
                        end
                    end
                    if (r_chk && !r_valid[r_chk_idx] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free_idx <= r_chk_idx;
                    end
                    if (r_chk && r_last) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    // re-read the chosen entry
                    r_addr <= tgt;
                    r_state <= ST_OUT;
                end
                ST_OUT: r_state <= ST_MOD;
                ST_MOD: begin
                    if (out_go) begin
                        r_used <= used_n;
                        if (!r_tick && need_any && !r_hit && r_free_ok) begin
                            r_valid[r_free_idx] <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ST_MOD uses mem_rdata read at r_addr (=tgt) in ST_OUT; r_addr is
    // held in ST_OUT and ST_MOD so rdata stays valid while stalled.

    chk_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == CW'($countones(r_valid))) else $error("fill count mismatch");
    chk_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ST_IDLE) else $error("ready outside idle");
    chk_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !m_axis_tready) |=> r_out_v) else $error("result dropped");
endmodule

// ===== rtl/core/ppba_ram.sv =====
// Generic single-port RAM with registered read.
module ppba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the per-process burst alert table: stream requests, predict, compare.
module tb_top;
    import ppba_pkg::*;

    localparam int NWIN = 32;
    localparam int QUIET_CYCLES = 48;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        bit        verdict;
        bit        canary;
        bit [2:0]  reason;
        bit        burst;
        bit [31:0] bcount;
        bit        full;
        bit [5:0]  used;
    } t_alert_result;

    // Holds predicted results in order; compares each returned result to the oldest one.
    class t_alert_scoreboard;
        t_alert_result pending[$];
        int            mismatches;
        int            checked;

        function void note_request(t_alert_result e);
            pending.push_back(e);
        endfunction

        function void flag(string what, longint unsigned e, longint unsigned a);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0h got %0h (result %0d)", what, e, a, checked);
        endfunction

        function void check_result(t_alert_result a);
            t_alert_result e;
            if (pending.size() == 0) begin
                flag("unexpected result", 0, 1);
                return;
            end
            e = pending.pop_front();
            if (a.verdict != e.verdict) flag("verdict", e.verdict, a.verdict);
            if (a.canary != e.canary) flag("canary_alert", e.canary, a.canary);
            if (a.reason != e.reason) flag("canary_reason_code", e.reason, a.reason);
            if (a.burst != e.burst) flag("burst_alert", e.burst, a.burst);
            if (a.bcount != e.bcount) flag("burst_count", e.bcount, a.bcount);
            if (a.full != e.full) flag("table_full", e.full, a.full);
            if (a.used != e.used) flag("entries_in_use", e.used, a.used);
            checked++;
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]  i_cfg_data;

    per_process_burst_alert_table i_dut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---- predictor state: config registers and the process table ----
    bit [15:0] thr_reg;
    bit [31:0] win_reg;
    bit [31:0] cool_reg;
    bit        deny_reg;
    bit        tbl_valid[NWIN];
    bit [21:0] tbl_pid[NWIN];
    bit [63:0] tbl_wstart[NWIN];
    bit [63:0] tbl_act[NWIN];
    bit [63:0] tbl_alert[NWIN];
    bit [31:0] tbl_cnt[NWIN];

    t_alert_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  stall_cycles;
    int  n_deny, n_canary, n_burst, n_full, n_tick;

    function automatic bit [2:0] classify_reason(bit [31:0] m);
        if ((m & DELETE_BITS) != 0) return RSN_DELETED;
        if ((m & RENAME_BITS) != 0) return RSN_RENAMED;
        if ((m & MODIFY_BITS) != 0) return RSN_MODIFIED;
        if ((m & OPEN_BITS) != 0) return RSN_OPENED;
        return RSN_NONE;
    endfunction

    // Existing slot for pid, else first free slot (initialized), else -1.
    function automatic int claim_slot(bit [21:0] pid, bit [63:0] now);
        for (int k = 0; k < NWIN; k++)
            if (tbl_valid[k] && tbl_pid[k] == pid) return k;
        for (int k = 0; k < NWIN; k++)
            if (!tbl_valid[k]) begin
                tbl_valid[k] = 1;
                tbl_pid[k] = pid;
                tbl_wstart[k] = 0;
                tbl_act[k] = now;
                tbl_alert[k] = 0;
                tbl_cnt[k] = 0;
                return k;
            end
        return -1;
    endfunction

    function automatic bit cooled_down(int k, bit [63:0] now);
        return tbl_alert[k] == 0 || (now - tbl_alert[k]) >= {32'd0, cool_reg};
    endfunction

    // Applies one request to the model table and returns the result it must give.
    function automatic t_alert_result predict_alert(bit tick, bit [21:0] pid, bit [63:0] now,
                                                    bit [31:0] mask, bit path_hit);
        t_alert_result r;
        bit [2:0] rsn;
        int k;
        int used;
        r = '{default: 0};
        if (tick) begin
            for (k = 0; k < NWIN; k++)
                if (tbl_valid[k] && (now - tbl_act[k]) > IDLE_MS) tbl_valid[k] = 0;
        end else begin
            rsn = classify_reason(mask);
            if ((mask & WATCHED_BITS) != 0 && path_hit && rsn != RSN_NONE) begin
                k = claim_slot(pid, now);
                if (k < 0) r.full = 1;
                else begin
                    if (cooled_down(k, now)) begin
                        tbl_alert[k] = now;
                        r.canary = 1;
                        r.reason = rsn;
                    end
                    tbl_act[k] = now;
                end
            end
            if (thr_reg != 0 && (mask & MUTATING_BITS) != 0) begin
                k = claim_slot(pid, now);
                if (k < 0) r.full = 1;
                else begin
                    if (tbl_cnt[k] == 0 || (now - tbl_wstart[k]) > {32'd0, win_reg}) begin
                        tbl_wstart[k] = now;
                        tbl_cnt[k] = 1;
                    end else if (tbl_cnt[k] != 32'hFFFF_FFFF) tbl_cnt[k]++;
                    tbl_act[k] = now;
                    if (tbl_cnt[k] >= {16'd0, thr_reg} && cooled_down(k, now)) begin
                        r.burst = 1;
                        r.bcount = tbl_cnt[k];
                        tbl_alert[k] = now;
                        tbl_cnt[k] = 0;
                        tbl_wstart[k] = now;
                    end
                end
            end
            r.verdict = (r.canary || r.burst) && (mask & PERM_BITS) != 0 && deny_reg;
        end
        used = 0;
        for (k = 0; k < NWIN; k++) used += tbl_valid[k];
        r.used = 6'(used);
        return r;
    endfunction

    // ---- drivers ----
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Register write while idle; zero window/cooldown fall back to defaults.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_THRESHOLD: thr_reg = val[15:0];
            CFG_WINDOW:    win_reg = (val != 0) ? val : DEF_WINDOW_MS;
            CFG_COOLDOWN:  cool_reg = (val != 0) ? val : DEF_COOLDOWN_MS;
            CFG_DENY:      deny_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(bit [15:0] thr, bit [31:0] win, bit [31:0] cool, bit deny);
        wait_drained();
        write_reg(CFG_THRESHOLD, {16'd0, thr});
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_COOLDOWN, cool);
        write_reg(CFG_DENY, {31'd0, deny});
    endtask

    // Present one request; valid stays high between back-to-back requests unless a random idle gap is inserted first.
    task automatic send_request(bit tick, bit [21:0] pid, bit [63:0] now,
                                bit [31:0] mask, bit path_hit);
        t_alert_result e;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= tick;
        s_axis_tdata  <= {1'b0, path_hit, mask, now, pid};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        e = predict_alert(tick, pid, now, mask, path_hit);
        n_tick   += tick;
        n_deny   += e.verdict;
        n_canary += e.canary;
        n_burst  += e.burst;
        n_full   += e.full;
        sb.note_request(e);
    endtask

    task automatic go_idle();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // ---- receiver and result monitor ----
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_alert_result a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a.verdict = m_axis_tdata[0];
            a.canary  = m_axis_tdata[1];
            a.reason  = m_axis_tdata[4:2];
            a.burst   = m_axis_tdata[5];
            a.bcount  = m_axis_tdata[37:6];
            a.full    = m_axis_tdata[38];
            a.used    = m_axis_tdata[44:39];
            sb.check_result(a);
        end
    end

    // Watchdog: too long with no handshake on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("per_process_burst_alert_table verification failed");
            $finish;
        end
    end

    // ---- stimulus ----
    bit [21:0] pid_pool[40];
    bit [63:0] clock_ms;

    // Mostly masks built from the classes the block cares about, some raw noise.
    function automatic bit [31:0] pick_mask();
        bit [31:0] m;
        case ($urandom_range(9))
            0: m = 32'h0000_0002;
            1: m = 32'h0000_0200;
            2: m = 32'h0000_0040;
            3: m = 32'h1000_0000;
            4: m = 32'h0000_0020;
            5: m = 32'h0001_0000;
            6: m = 32'h0000_0008 | 32'h0000_0100;
            7: m = 32'h0000_0001;
            default: m = $urandom();
        endcase
        if ($urandom_range(2) == 0) m |= (32'h1_0000 << $urandom_range(2));
        return m;
    endfunction

    task automatic random_burst_phase(int n_items);
        bit [21:0] pid;
        for (int n = 0; n < n_items; n++) begin
            case ($urandom_range(19))
                0: clock_ms += 64'd61000 + $urandom_range(5000);
                1, 2: clock_ms += $urandom_range(3000, 7000);
                default: clock_ms += $urandom_range(0, 400);
            endcase
            if ($urandom_range(11) == 0)
                send_request(1'b1, 22'($urandom()), clock_ms, $urandom(),
                             1'($urandom_range(1)));
            else begin
                // small pool keeps hitting live entries; raw ids give fresh ones
                pid = ($urandom_range(9) == 0) ? 22'($urandom()) :
                      pid_pool[$urandom_range(($urandom_range(3) == 0) ? 39 : 11)];
                send_request(1'b0, pid, clock_ms, pick_mask(), $urandom_range(2) != 0);
            end
            // hold off once until the pipeline has fully drained
            if (n == n_items / 2) begin
                go_idle();
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end
        go_idle();
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        stall_cycles = 0;
        thr_reg = 0;
        win_reg = DEF_WINDOW_MS;
        cool_reg = DEF_COOLDOWN_MS;
        deny_reg = 0;
        foreach (tbl_valid[k]) tbl_valid[k] = 0;
        foreach (pid_pool[k]) pid_pool[k] = $urandom();
        pid_pool[0] = 22'h0;
        pid_pool[1] = 22'h3F_FFFF;
        send_idle_pct = 26;
        recv_idle_pct = 61;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults first (counting off), then tight burst settings
        send_request(1'b0, 22'h0, 64'd0, 32'h0000_0200, 1'b1);          // delete, stamped at 0
        send_request(1'b0, 22'h0, 64'd10, 32'h0000_0040, 1'b1);         // never-alerted rule
        send_request(1'b0, 22'h3F_FFFF, 64'd20, 32'h0000_0002, 1'b1);   // modified
        send_request(1'b0, 22'h1234, 64'd30, 32'h0004_0000, 1'b1);      // opened (perm)
        send_request(1'b0, 22'h1234, 64'd40, 32'h0000_0001, 1'b1);      // not watched
        send_request(1'b0, 22'h1235, 64'd50, 32'hFFFF_FFFF, 1'b0);
        send_request(1'b1, 22'h0, 64'd60, 32'h0, 1'b0);                // tick, nothing idle
        go_idle();
        configure(16'd2, 32'd1, 32'd1, 1'b1);
        send_request(1'b0, 22'h77, 64'd100, 32'h0001_0002, 1'b0);
        send_request(1'b0, 22'h77, 64'd101, 32'h0001_0002, 1'b0);       // burst, deny
        send_request(1'b0, 22'h77, 64'd105, 32'h0000_0100, 1'b0);       // window ran out
        send_request(1'b0, 22'h77, 64'd105, 32'h0002_0200, 1'b1);       // canary; its stamp blocks the burst
        send_request(1'b0, 22'h77, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0008, 1'b0);
        send_request(1'b1, 22'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1); // wrapped time
        send_request(1'b1, 22'h0, 64'd200000, 32'h0, 1'b0);            // idle sweep frees all
        for (int k = 0; k < 34; k++)                                     // fill past capacity
            send_request(1'b0, 22'(k + 500), 64'd300000, 32'h0000_0004, 1'b0);
        go_idle();

        // random phases: three idling patterns, several register settings
        clock_ms = 64'd400000;
        configure(16'd3, 32'd800, 32'd2000, 1'b1);
        random_burst_phase(180);
        configure(16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        random_burst_phase(180);
        send_idle_pct = 61;
        recv_idle_pct = 26;
        configure(16'd1, 32'd0, 32'd0, 1'b1);
        random_burst_phase(180);
        clock_ms = 64'hFFFF_FFFF_FFFE_0000;                             // cross the 2^64 wrap
        configure(16'($urandom_range(2, 6)), $urandom_range(100, 3000),
                  $urandom_range(1, 4000), 1'b1);
        random_burst_phase(180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16'd0, 32'd1, 32'd1, 1'b1);
        random_burst_phase(180);
        configure(16'($urandom_range(1, 4)), 32'd1000, 32'd1, 1'b0);
        random_burst_phase(180);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        $display("covered %0d results: %0d ticks, %0d canary, %0d burst, %0d deny, %0d full",
                 sb.checked, n_tick, n_canary, n_burst, n_deny, n_full);
        $display("six register settings incl. extremes, three idling patterns, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("per_process_burst_alert_table verification clean");
        else
            $display("per_process_burst_alert_table verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ppba_pkg.sv
rtl/core/ppba_ram.sv
rtl/core/per_process_burst_alert_table.sv
test/tb_top.sv
